### hdl/clle_pkg.sv
// Package for the cursor linked list engine: sizes, opcodes, status codes
// and controller states. No dependencies.
package clle_pkg;
	localparam int CAPACITY = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W = $clog2(CAPACITY + 1);
	localparam int ADDR_W = $clog2(CAPACITY);
	localparam logic [IDX_W-1:0] NIL = IDX_W'(CAPACITY);

	typedef enum logic [3:0] {
		OP_CLEAR = 4'd0, OP_INS_AFTER = 4'd1, OP_INS_BEFORE = 4'd2, OP_PEEK = 4'd3,
		OP_PEEK_NEXT = 4'd4, OP_UPDATE = 4'd5, OP_DELETE = 4'd6, OP_FIRST = 4'd7,
		OP_NEXT = 4'd8, OP_LAST = 4'd9, OP_QUERY = 4'd10
	} opcode_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_EMPTY = 3'd1, ST_NO_CUR = 3'd2, ST_NO_NEXT = 3'd3, ST_FULL = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_EVAL, S_RD2, S_WALK, S_LINK, S_FIX, S_DONE
	} state_t;

	typedef struct packed {
		logic              lwe;
		logic [ADDR_W-1:0] lwa;
		logic [IDX_W-1:0]  lwd;
		logic              vwe;
		logic [ADDR_W-1:0] vwa;
		logic [DATA_WIDTH-1:0] vwd;
		logic [ADDR_W-1:0] ra;
	} mem_ctl_t;
endpackage

### hdl/clle_store.sv
// Link and value memories with registered reads.
// Depends on clle_pkg.
module clle_store
	import clle_pkg::*;
(
	input  logic                  clk,
	input  mem_ctl_t              ctl,
	output logic [IDX_W-1:0]      link_q,
	output logic [DATA_WIDTH-1:0] val_q
);
	logic [IDX_W-1:0]      link_mem [CAPACITY];
	logic [DATA_WIDTH-1:0] val_mem  [CAPACITY];

	always_ff @(posedge clk) begin
		if (ctl.lwe) link_mem[ctl.lwa] <= ctl.lwd;
		if (ctl.vwe) val_mem[ctl.vwa] <= ctl.vwd;
		link_q <= link_mem[ctl.ra];
		val_q <= val_mem[ctl.ra];
	end
endmodule

### hdl/cursor_linked_list_engine.sv
// Top level of the cursor linked list engine: controller and list registers.
// Depends on clle_pkg and clle_store.
//
//   channel   direction  handshake         fields
//   command   in         start & !busy     opcode, data_in
//   result    out        done (one cycle)  status, data_out, count, flags
//
// done is registered from the state that ends the operation: evaluate for simple
// operations, a second read for a successful peek next, and link then fix for insert
// after a cursor. Insert before and delete of a non-head element walk the link memory
// from head, one read per cycle, to the predecessor; a delete then passes the fix state.
// busy stays high through the done cycle.
// Reset clears all list registers; memories need no clearing. Results cannot be stalled.
module cursor_linked_list_engine
	import clle_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [3:0]            opcode,
	input  logic [31:0]           data_in,
	output logic                  done,
	output logic [2:0]            status,
	output logic [31:0]           data_out,
	output logic [4:0]            count,
	output logic                  is_empty,
	output logic                  has_current,
	output logic                  has_next
);
	state_t state_q, state_d;
	logic [IDX_W-1:0] head_q, tail_q, cur_q, free_q, nun_q, cnt_q, walk_q, slot_q;
	logic [IDX_W-1:0] head_d, tail_d, cur_d, free_d, nun_d, cnt_d, walk_d, slot_d;
	logic [IDX_W-1:0] new_slot;
	logic [3:0] op_q;
	logic [DATA_WIDTH-1:0] din_q, dval_q, dval_d;
	logic [2:0] st_d;
	logic [DATA_WIDTH-1:0] dout_d;
	logic done_d;
	logic [2:0] st_q;
	logic [DATA_WIDTH-1:0] dout_q;
	logic done_q;
	mem_ctl_t ctl;
	logic [IDX_W-1:0] link_rd;
	logic [DATA_WIDTH-1:0] val_rd;
	logic empty, cur_ok;

	clle_store u_store (.clk(clk), .ctl(ctl), .link_q(link_rd), .val_q(val_rd));

	function automatic logic [ADDR_W-1:0] ad(input logic [IDX_W-1:0] i);
		return i[ADDR_W-1:0];
	endfunction

	assign empty = (cnt_q == '0);
	assign cur_ok = (cur_q != NIL);
	assign new_slot = (free_q != NIL) ? free_q : nun_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= NIL; tail_q <= NIL; cur_q <= NIL; free_q <= NIL;
			nun_q <= '0; cnt_q <= '0; done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d; tail_q <= tail_d; cur_q <= cur_d; free_q <= free_d;
			nun_q <= nun_d; cnt_q <= cnt_d; done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= opcode;
			din_q <= data_in[DATA_WIDTH-1:0];
		end
		walk_q <= walk_d;
		slot_q <= slot_d;
		dval_q <= dval_d;
		if (done_d) begin
			st_q <= st_d;
			dout_q <= dout_d;
		end
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q; tail_d = tail_q; cur_d = cur_q; free_d = free_q;
		nun_d = nun_q; cnt_d = cnt_q; walk_d = walk_q; slot_d = slot_q; dval_d = dval_q;
		st_d = ST_OK; dout_d = '0; done_d = 1'b0;
		ctl = '0;
		ctl.ra = ad(cur_q);
		unique case (state_q)
			S_IDLE: begin
				if (start) state_d = S_RD;
			end
			S_RD: begin
				// Read at the cursor, or at the free head for inserts.
				state_d = S_EVAL;
				if (op_q == OP_INS_AFTER || op_q == OP_INS_BEFORE) ctl.ra = ad(free_q);
			end
			S_EVAL: begin
				state_d = S_DONE;
				done_d = 1'b1;
				unique case (op_q)
					OP_CLEAR: begin
						head_d = NIL; tail_d = NIL; cur_d = NIL; free_d = NIL;
						nun_d = '0; cnt_d = '0;
					end
					OP_INS_AFTER, OP_INS_BEFORE: begin
						if (!cur_ok && !empty) st_d = ST_NO_CUR;
						else if (free_q == NIL && nun_q == NIL) st_d = ST_FULL;
						else begin
							slot_d = new_slot;
							if (free_q != NIL) free_d = link_rd;
							else nun_d = nun_q + IDX_W'(1);
							cnt_d = cnt_q + IDX_W'(1);
							ctl.vwe = 1'b1; ctl.vwa = ad(new_slot); ctl.vwd = din_q;
							if (!cur_ok) begin
								ctl.lwe = 1'b1; ctl.lwa = ad(new_slot); ctl.lwd = NIL;
								head_d = new_slot; tail_d = new_slot; cur_d = new_slot;
							end else if (op_q == OP_INS_AFTER) begin
								done_d = 1'b0; state_d = S_LINK; ctl.ra = ad(cur_q);
							end else begin
								ctl.lwe = 1'b1; ctl.lwa = ad(new_slot); ctl.lwd = cur_q;
								if (head_q == cur_q) begin
									head_d = new_slot; cur_d = new_slot;
								end else begin
									done_d = 1'b0; state_d = S_WALK; ctl.ra = ad(head_q);
									walk_d = head_q;
								end
							end
						end
					end
					OP_PEEK, OP_PEEK_NEXT, OP_UPDATE, OP_DELETE, OP_NEXT: begin
						if (empty) st_d = ST_EMPTY;
						else if (!cur_ok) st_d = ST_NO_CUR;
						else begin
							unique case (op_q)
								OP_PEEK: dout_d = val_rd;
								OP_PEEK_NEXT: begin
									if (link_rd == NIL) st_d = ST_NO_NEXT;
									else begin
										done_d = 1'b0; state_d = S_RD2; ctl.ra = ad(link_rd);
									end
								end
								OP_UPDATE: begin
									ctl.vwe = 1'b1; ctl.vwa = ad(cur_q); ctl.vwd = din_q;
								end
								OP_NEXT: cur_d = link_rd;
								default: begin
									if (head_q == cur_q) begin
										dout_d = val_rd;
										ctl.lwe = 1'b1; ctl.lwa = ad(cur_q); ctl.lwd = free_q;
										free_d = cur_q; cnt_d = cnt_q - IDX_W'(1);
										head_d = link_rd; cur_d = link_rd;
										if (link_rd == NIL) tail_d = NIL;
									end else begin
										dval_d = val_rd; slot_d = link_rd;
										done_d = 1'b0; state_d = S_WALK; ctl.ra = ad(head_q);
										walk_d = head_q;
									end
								end
							endcase
						end
					end
					OP_FIRST, OP_LAST: begin
						if (empty) st_d = ST_EMPTY;
						else cur_d = (op_q == OP_FIRST) ? head_q : tail_q;
					end
					default: ;
				endcase
			end
			S_RD2: begin
				dout_d = val_rd; done_d = 1'b1; state_d = S_DONE;
			end
			S_WALK: begin
				// link_rd is the successor of walk_q.
				if (link_rd == cur_q) begin
					ctl.lwe = 1'b1; ctl.lwa = ad(walk_q); ctl.lwd = slot_q;
					if (op_q == OP_INS_BEFORE) begin
						cur_d = slot_q; done_d = 1'b1; state_d = S_DONE;
					end else begin
						if (tail_q == cur_q) tail_d = walk_q;
						state_d = S_FIX;
					end
				end else begin
					walk_d = link_rd; ctl.ra = ad(link_rd);
				end
			end
			S_LINK: begin
				ctl.lwe = 1'b1; ctl.lwa = ad(slot_q); ctl.lwd = link_rd;
				state_d = S_FIX;
			end
			S_FIX: begin
				ctl.lwe = 1'b1; ctl.lwa = ad(cur_q);
				done_d = 1'b1; state_d = S_DONE;
				if (op_q == OP_INS_AFTER) begin
					ctl.lwd = slot_q;
					if (tail_q == cur_q) tail_d = slot_q;
					cur_d = slot_q;
				end else begin
					ctl.lwd = free_q;
					free_d = cur_q; cur_d = walk_q; cnt_d = cnt_q - IDX_W'(1);
					dout_d = dval_q;
				end
			end
			S_DONE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign status = st_q;
	assign data_out = dout_q;
	assign count = cnt_q[4:0];
	assign is_empty = empty;
	assign has_current = cur_ok;
	assign has_next = cur_ok && (tail_q != cur_q);
endmodule

### hdl/clle_checker.sv
// Port-level checker for the cursor linked list engine, bound to the top level.
// Depends on cursor_linked_list_engine.
module clle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [4:0] count,
	input logic       is_empty,
	input logic       has_current,
	input logic       has_next
);
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("start not taken");
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (is_empty == (count == 5'd0))) else $error("empty flag wrong");
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		done && has_next |-> has_current) else $error("next without current");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> count <= 5'd16) else $error("count out of range");
	a_cur: assert property (@(posedge clk) disable iff (!arst_n)
		done && is_empty |-> !has_current) else $error("cursor in empty list");
endmodule

bind cursor_linked_list_engine clle_checker u_clle_checker (.*);
